### rtl/rpfg_pkg.sv
// shared constants and tables for the polygon fan generator
`timescale 1ns / 1ps
package rpfg_pkg;

    localparam int MAX_SIDES_DEF      = 20;
    localparam int INDEX_CAPACITY_DEF = 65536;
    localparam int CORDIC_STEPS_DEF   = 16;

    localparam int ATAN_ENTRIES = 24;
    localparam logic [31:0] GAIN_Q31 = 32'd1304065748;

    localparam logic [4:0]  NUM_SIDES_RESET = 5'd3;
    localparam logic [14:0] RADIUS_RESET    = 15'd1638;

    localparam logic       REG_NUM_SIDES = 1'b0;
    localparam logic       REG_RADIUS    = 1'b1;
    localparam logic       OP_SPAWN      = 1'b0;
    localparam logic       OP_CLEAR      = 1'b1;
    localparam logic       KIND_VERTEX   = 1'b0;
    localparam logic       KIND_TRIANGLE = 1'b1;

    function automatic logic [31:0] atan_turn(input logic [4:0] k);
        logic [31:0] r;
        begin
            case (k)
                5'd0:  r = 32'h20000000;
                5'd1:  r = 32'h12E4051E;
                5'd2:  r = 32'h09FB385B;
                5'd3:  r = 32'h051111D4;
                5'd4:  r = 32'h028B0D43;
                5'd5:  r = 32'h0145D7E1;
                5'd6:  r = 32'h00A2F61E;
                5'd7:  r = 32'h00517C55;
                5'd8:  r = 32'h0028BE53;
                5'd9:  r = 32'h00145F2F;
                5'd10: r = 32'h000A2F98;
                5'd11: r = 32'h000517CC;
                5'd12: r = 32'h00028BE6;
                5'd13: r = 32'h000145F3;
                5'd14: r = 32'h0000A2FA;
                5'd15: r = 32'h0000517D;
                5'd16: r = 32'h000028BE;
                5'd17: r = 32'h0000145F;
                5'd18: r = 32'h00000A30;
                5'd19: r = 32'h00000518;
                5'd20: r = 32'h0000028C;
                5'd21: r = 32'h00000146;
                5'd22: r = 32'h000000A3;
                5'd23: r = 32'h00000051;
                default: r = 32'h0;
            endcase
            return r;
        end
    endfunction

endpackage

### rtl/regular_polygon_fan_generator.sv
// polygon fan generator top level: sequencer, shared cordic datapath, output register
`timescale 1ns / 1ps
// A spawn transaction (opcode 0) produces n vertex transactions followed by n-2 triangle
// transactions, n being num_sides clamped to 3..MAX_SIDES; a clear transaction (opcode 1)
// resets the running vertex base and produces nothing. The block handles one command at a
// time. Each vertex passes a check state, then a restoring division of (2i+e)*2^31 by n,
// one dividend bit per cycle, which finds the vertex angle, then a load state, CORDIC_STEPS
// iterations of one shared add/shift rotator, a rounding state and an emit state, which
// output stalls hold. A spawn that would overflow INDEX_CAPACITY yields a single
// transaction with full_res set.
module regular_polygon_fan_generator
    import rpfg_pkg::*;
#(
    parameter int MAX_SIDES      = MAX_SIDES_DEF,
    parameter int INDEX_CAPACITY = INDEX_CAPACITY_DEF,
    parameter int CORDIC_STEPS   = CORDIC_STEPS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [14:0] cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // center_x, center_y
    input  logic        s_axis_tuser,   // opcode
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [79:0] m_axis_tdata,   // vert_x, vert_y, index_first, index_second, index_third
    output logic [1:0]  m_axis_tuser,   // kind, full_res
    output logic        m_axis_tlast
);

    localparam int SW = $clog2(MAX_SIDES + 1);
    localparam int KW = 5;
    // dividend is {2i+e, 31 zeros}
    localparam int DW = SW + 32;

    typedef enum logic [3:0] {
        S_IDLE, S_CHECK, S_DIV, S_LOAD, S_ROT, S_ROUND, S_EMITV, S_EMITT, S_FULL, S_WAIT
    } state_t;

    state_t      state_reg;
    logic [4:0]  num_sides_reg;
    logic [14:0] radius_reg;
    logic [16:0] base_reg;
    logic [15:0] cx_reg, cy_reg;
    logic [SW-1:0] n_reg, i_reg;
    logic [5:0]  cnt_reg;
    logic [31:0] rem_reg, quo_reg;
    logic [DW-1:0] dvd_reg;
    logic signed [49:0] x_reg, y_reg;
    logic signed [32:0] z_reg;
    logic [KW-1:0] k_reg;
    logic          out_valid_reg;
    logic [79:0]   out_data_reg;
    logic [1:0]    out_user_reg;
    logic          out_last_reg;
    logic [46:0]   mag_reg;

    // clamp side count
    logic [SW-1:0] n_clamp;
    always_comb
    begin
        if (num_sides_reg < 5'd3)
            n_clamp = SW'(3);
        else if (32'(num_sides_reg) > MAX_SIDES)
            n_clamp = SW'(MAX_SIDES);
        else
            n_clamp = SW'(num_sides_reg);
    end

    // restoring division step
    logic [32:0] rem_shift;
    logic [32:0] rem_sub;
    assign rem_shift = {rem_reg, dvd_reg[DW-1]};
    assign rem_sub   = rem_shift - 33'(n_reg);

    logic [31:0] angle;
    assign angle = 32'h40000000 + quo_reg;

    // one cordic rotation step
    logic signed [49:0] dx, dy;
    logic signed [32:0] at;
    assign dx = y_reg >>> k_reg;
    assign dy = x_reg >>> k_reg;
    assign at = $signed({1'b0, atan_turn(k_reg)});

    logic signed [49:0] rx, ry;
    assign rx = (x_reg + 50'sh40000000) >>> 31;
    assign ry = (y_reg + 50'sh40000000) >>> 31;

    logic signed [49:0] sx, sy;
    logic [15:0] vx_sat, vy_sat;
    assign sx = rx + 50'($signed(cx_reg));
    assign sy = ry + 50'($signed(cy_reg));
    always_comb
    begin
        if (sx > 50'sd32767) vx_sat = 16'h7FFF;
        else if (sx < -50'sd32768) vx_sat = 16'h8000;
        else vx_sat = sx[15:0];
        if (sy > 50'sd32767) vy_sat = 16'h7FFF;
        else if (sy < -50'sd32768) vy_sat = 16'h8000;
        else vy_sat = sy[15:0];
    end

    logic [16:0] b1, b2;
    assign b1 = base_reg + 17'(i_reg) + 17'd1;
    assign b2 = base_reg + 17'(i_reg) + 17'd2;

    logic out_free;
    assign out_free = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = (state_reg == S_IDLE);

    logic emit;
    assign emit = out_free &&
                  (state_reg == S_EMITV || state_reg == S_EMITT || state_reg == S_FULL);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            num_sides_reg <= NUM_SIDES_RESET;
            radius_reg    <= RADIUS_RESET;
            base_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == REG_NUM_SIDES)
                    num_sides_reg <= cfg_data[4:0];
                else
                    radius_reg <= cfg_data;
            end
            if (emit)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (s_axis_tvalid)
                    begin
                        cx_reg <= s_axis_tdata[15:0];
                        cy_reg <= s_axis_tdata[31:16];
                        if (s_axis_tuser == OP_CLEAR)
                        begin
                            base_reg  <= '0;
                            state_reg <= S_WAIT;
                        end
                        else
                        begin
                            n_reg     <= n_clamp;
                            i_reg     <= '0;
                            mag_reg   <= 47'(radius_reg) * 47'(GAIN_Q31);
                            state_reg <= S_CHECK;
                        end
                    end
                end
                S_WAIT:
                    state_reg <= S_IDLE;
                S_CHECK:
                begin
                    if (18'(base_reg) + 18'(n_reg) > 18'(INDEX_CAPACITY))
                        state_reg <= S_FULL;
                    else
                    begin
                        dvd_reg   <= {i_reg, !n_reg[0], 31'b0};
                        rem_reg   <= '0;
                        cnt_reg   <= '0;
                        state_reg <= S_DIV;
                    end
                end
                S_DIV:
                begin
                    // shifts in dividend bits, msb first, to form quotient
                    if (!rem_sub[32])
                        rem_reg <= rem_sub[31:0];
                    else
                        rem_reg <= rem_shift[31:0];
                    quo_reg <= {quo_reg[30:0], !rem_sub[32]};
                    dvd_reg <= {dvd_reg[DW-2:0], 1'b0};
                    cnt_reg <= cnt_reg + 6'd1;
                    if (cnt_reg == 6'(DW - 1))
                        state_reg <= S_LOAD;
                end
                S_LOAD:
                begin
                    case (angle[31:30])
                        2'd0:    begin x_reg <= 50'(mag_reg);  y_reg <= '0; end
                        2'd1:    begin x_reg <= '0; y_reg <= 50'(mag_reg); end
                        2'd2:    begin x_reg <= -50'(mag_reg); y_reg <= '0; end
                        default: begin x_reg <= '0; y_reg <= -50'(mag_reg); end
                    endcase
                    z_reg     <= $signed({3'b0, angle[29:0]});
                    k_reg     <= '0;
                    state_reg <= S_ROT;
                end
                S_ROT:
                begin
                    if (!z_reg[32])
                    begin
                        x_reg <= x_reg - dx; y_reg <= y_reg + dy; z_reg <= z_reg - at;
                    end
                    else
                    begin
                        x_reg <= x_reg + dx; y_reg <= y_reg - dy; z_reg <= z_reg + at;
                    end
                    k_reg <= k_reg + KW'(1);
                    if (32'(k_reg) == CORDIC_STEPS - 1)
                        state_reg <= S_ROUND;
                end
                S_ROUND:
                    state_reg <= S_EMITV;
                S_EMITV:
                begin
                    if (out_free)
                    begin
                        out_data_reg  <= {48'b0, vy_sat, vx_sat};
                        out_user_reg  <= {1'b0, KIND_VERTEX};
                        out_last_reg  <= 1'b0;
                        if (i_reg == n_reg - SW'(1))
                        begin
                            i_reg     <= '0;
                            state_reg <= S_EMITT;
                        end
                        else
                        begin
                            i_reg     <= i_reg + SW'(1);
                            state_reg <= S_CHECK;
                        end
                    end
                end
                S_EMITT:
                begin
                    if (out_free)
                    begin
                        out_data_reg  <= {b2[15:0], b1[15:0], base_reg[15:0], 32'b0};
                        out_user_reg  <= {1'b0, KIND_TRIANGLE};
                        out_last_reg  <= (i_reg + SW'(3) == n_reg);
                        i_reg         <= i_reg + SW'(1);
                        if (i_reg + SW'(3) == n_reg)
                        begin
                            base_reg  <= base_reg + 17'(n_reg);
                            state_reg <= S_IDLE;
                        end
                    end
                end
                S_FULL:
                begin
                    if (out_free)
                    begin
                        out_data_reg  <= '0;
                        out_user_reg  <= {1'b1, KIND_VERTEX};
                        out_last_reg  <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_user_reg;
    assign m_axis_tlast  = out_last_reg;

    // output must hold while stalled
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output changed under stall");
    // not ready while working
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != S_IDLE |-> !s_axis_tready)
        else $error("ready during work");
    // full flag only on a last transaction
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tlast)
        else $error("full without last");

endmodule
